// ===== rtl/order_book_level_updater_assert.svh =====
`ifndef ORDER_BOOK_LEVEL_UPDATER_ASSERT_SVH
`define ORDER_BOOK_LEVEL_UPDATER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define OBLU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("order book assertion failed");

// Next-cycle implication, checked outside reset.
`define OBLU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("order book assertion failed");

`endif

// ===== rtl/oblu_pkg.sv =====
package oblu_pkg;

    localparam int BOOK_DEPTH = 256;
    localparam int IDX_W      = $clog2(BOOK_DEPTH);
    localparam int CNT_W      = IDX_W + 1;
    localparam int PW         = 63;
    localparam int SEQ_W      = 64;
    localparam int LC_W       = 10;
    localparam int ENTRY_W    = 2 * PW;
    localparam int IN_W       = 264;
    localparam int OUT_W      = 336;

    localparam logic [1:0] MODE_SNAP_START  = 2'd0;
    localparam logic [1:0] MODE_SNAP_LEVEL  = 2'd1;
    localparam logic [1:0] MODE_EVENT_HDR   = 2'd2;
    localparam logic [1:0] MODE_EVENT_LEVEL = 2'd3;

    localparam logic [1:0] ST_APPLIED  = 2'd0;
    localparam logic [1:0] ST_STALE    = 2'd1;
    localparam logic [1:0] ST_GAP      = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SIMPLE,
        CMD_SEARCH_INIT,
        CMD_READ_I,
        CMD_NEXT_I,
        CMD_LATCH_HIT,
        CMD_WRITE_HIT,
        CMD_OVERFLOW,
        CMD_ER_INIT,
        CMD_READ_UP,
        CMD_WRITE_UP,
        CMD_ER_END,
        CMD_IN_INIT,
        CMD_READ_DOWN,
        CMD_WRITE_DOWN,
        CMD_IN_END,
        CMD_EMIT
    } cmd_t;

    typedef struct packed {
        logic level_op;
        logic erase;
        logic i_end;
        logic keep;
        logic hit;
        logic i_full;
        logic up_end;
        logic j_at_i;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/oblu_ctrl.sv =====
module oblu_ctrl
    import oblu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  dp_status_t stat,
    output logic       in_ready,
    output cmd_t       cmd
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_DISPATCH = 10'b0000000010,
        S_SRCH_RD  = 10'b0000000100,
        S_SRCH_CMP = 10'b0000001000,
        S_RESOLVE  = 10'b0000010000,
        S_ER_RD    = 10'b0000100000,
        S_ER_WR    = 10'b0001000000,
        S_IN_RD    = 10'b0010000000,
        S_IN_WR    = 10'b0100000000,
        S_EMIT     = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = CMD_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.level_op)
                begin
                    cmd        = CMD_SEARCH_INIT;
                    state_next = S_SRCH_RD;
                end
                else
                begin
                    cmd        = CMD_SIMPLE;
                    state_next = S_EMIT;
                end
            end
            S_SRCH_RD:
            begin
                if (stat.i_end)
                begin
                    state_next = S_RESOLVE;
                end
                else
                begin
                    cmd        = CMD_READ_I;
                    state_next = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP:
            begin
                if (stat.keep)
                begin
                    cmd        = CMD_NEXT_I;
                    state_next = S_SRCH_RD;
                end
                else
                begin
                    cmd        = CMD_LATCH_HIT;
                    state_next = S_RESOLVE;
                end
            end
            S_RESOLVE:
            begin
                if (stat.erase)
                begin
                    if (stat.hit)
                    begin
                        cmd        = CMD_ER_INIT;
                        state_next = S_ER_RD;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
                else if (stat.hit)
                begin
                    cmd        = CMD_WRITE_HIT;
                    state_next = S_EMIT;
                end
                else if (stat.i_full)
                begin
                    cmd        = CMD_OVERFLOW;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd        = CMD_IN_INIT;
                    state_next = S_IN_RD;
                end
            end
            S_ER_RD:
            begin
                if (stat.up_end)
                begin
                    cmd        = CMD_ER_END;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd        = CMD_READ_UP;
                    state_next = S_ER_WR;
                end
            end
            S_ER_WR:
            begin
                cmd        = CMD_WRITE_UP;
                state_next = S_ER_RD;
            end
            S_IN_RD:
            begin
                if (stat.j_at_i)
                begin
                    cmd        = CMD_IN_END;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd        = CMD_READ_DOWN;
                    state_next = S_IN_WR;
                end
            end
            S_IN_WR:
            begin
                cmd        = CMD_WRITE_DOWN;
                state_next = S_IN_RD;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd        = CMD_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/oblu_datapath.sv =====
module oblu_datapath
    import oblu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    input  logic [IN_W-1:0]  in_data,
    input  logic             out_ready,
    output dp_status_t       stat,
    output logic             out_valid,
    output logic [OUT_W-1:0] out_data
);

    logic [1:0]       mode_reg;
    logic             side_reg;
    logic [PW-1:0]    price_reg;
    logic [PW-1:0]    qty_reg;
    logic [SEQ_W-1:0] first_reg;
    logic [SEQ_W-1:0] last_reg;

    logic [CNT_W-1:0] bid_cnt_reg, ask_cnt_reg;
    logic [SEQ_W-1:0] seq_reg;
    logic             open_reg;
    logic [1:0]       evst_reg;
    logic [1:0]       status_reg;
    logic [CNT_W-1:0] i_reg;
    logic [IDX_W-1:0] j_reg;
    logic             hit_reg;
    logic [ENTRY_W-1:0] rd_reg;
    logic [ENTRY_W-1:0] bid_top_reg, ask_top_reg;
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_reg;

    logic [ENTRY_W-1:0] mem [2*BOOK_DEPTH];

    logic [CNT_W-1:0]   n;
    logic               n_full;
    logic [PW-1:0]      rd_price;
    logic               re, we;
    logic [IDX_W-1:0]   ridx, widx;
    logic [ENTRY_W-1:0] wdata;
    logic [CNT_W-1:0]   j_ext;
    logic [SEQ_W-1:0]   seq_plus;
    logic [1:0]         hdr_status;
    logic [CNT_W-1:0]   bid_show, ask_show;
    logic [LC_W-1:0]    level_sum;

    assign n        = side_reg ? ask_cnt_reg : bid_cnt_reg;
    assign n_full   = (n == CNT_W'(BOOK_DEPTH));
    assign rd_price = rd_reg[ENTRY_W-1:PW];
    assign j_ext    = {1'b0, j_reg};
    assign seq_plus = seq_reg + SEQ_W'(1);

    always_comb
    begin
        if (last_reg < seq_reg)
        begin
            hdr_status = ST_STALE;
        end
        else if ((seq_reg != '1) && (first_reg > seq_plus))
        begin
            hdr_status = ST_GAP;
        end
        else
        begin
            hdr_status = ST_APPLIED;
        end
    end

    always_comb
    begin
        stat.level_op = ((mode_reg == MODE_SNAP_LEVEL) && (qty_reg != '0))
                      || ((mode_reg == MODE_EVENT_LEVEL) && open_reg);
        stat.erase    = (qty_reg == '0);
        stat.i_end    = (i_reg == n);
        stat.keep     = (qty_reg == '0) ? (rd_price != price_reg)
                      : (side_reg ? (rd_price < price_reg) : (rd_price > price_reg));
        stat.hit      = hit_reg;
        stat.i_full   = (i_reg == CNT_W'(BOOK_DEPTH));
        stat.up_end   = ((j_ext + CNT_W'(1)) >= n);
        stat.j_at_i   = (j_ext == i_reg);
        stat.out_free = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        re    = 1'b0;
        we    = 1'b0;
        ridx  = i_reg[IDX_W-1:0];
        widx  = i_reg[IDX_W-1:0];
        wdata = {price_reg, qty_reg};
        unique case (cmd)
            CMD_READ_I:     re = 1'b1;
            CMD_READ_UP:
            begin
                re   = 1'b1;
                ridx = j_reg + IDX_W'(1);
            end
            CMD_READ_DOWN:
            begin
                re   = 1'b1;
                ridx = j_reg - IDX_W'(1);
            end
            CMD_WRITE_HIT:  we = 1'b1;
            CMD_IN_END:     we = 1'b1;
            CMD_WRITE_UP, CMD_WRITE_DOWN:
            begin
                we    = 1'b1;
                widx  = j_reg;
                wdata = rd_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[{side_reg, widx}] <= wdata;
        end
        if (re)
        begin
            rd_reg <= mem[{side_reg, ridx}];
        end
        if (we && (widx == '0))
        begin
            if (side_reg)
            begin
                ask_top_reg <= wdata;
            end
            else
            begin
                bid_top_reg <= wdata;
            end
        end
        if (cmd == CMD_LOAD)
        begin
            mode_reg  <= in_data[1:0];
            side_reg  <= in_data[2];
            price_reg <= in_data[65:3];
            qty_reg   <= in_data[128:66];
            first_reg <= in_data[192:129];
            last_reg  <= in_data[256:193];
        end
        if (cmd == CMD_EMIT)
        begin
            out_reg <= {6'd0, level_sum, seq_reg,
                        (ask_show != '0) ? {ask_top_reg[PW-1:0], ask_top_reg[ENTRY_W-1:PW]}
                                         : {ENTRY_W{1'b0}},
                        (ask_show != '0),
                        (bid_show != '0) ? {bid_top_reg[PW-1:0], bid_top_reg[ENTRY_W-1:PW]}
                                         : {ENTRY_W{1'b0}},
                        (bid_show != '0),
                        status_reg};
        end
    end

    assign bid_show  = bid_cnt_reg;
    assign ask_show  = ask_cnt_reg;
    assign level_sum = LC_W'({1'b0, bid_cnt_reg} + {1'b0, ask_cnt_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bid_cnt_reg   <= '0;
            ask_cnt_reg   <= '0;
            seq_reg       <= '0;
            open_reg      <= 1'b0;
            evst_reg      <= ST_APPLIED;
            status_reg    <= ST_APPLIED;
            i_reg         <= '0;
            j_reg         <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd == CMD_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (cmd)
                CMD_SIMPLE:
                begin
                    unique case (mode_reg)
                        MODE_SNAP_START:
                        begin
                            status_reg  <= ST_APPLIED;
                            bid_cnt_reg <= '0;
                            ask_cnt_reg <= '0;
                            seq_reg     <= last_reg;
                            open_reg    <= 1'b0;
                            evst_reg    <= ST_APPLIED;
                        end
                        MODE_EVENT_HDR:
                        begin
                            status_reg <= hdr_status;
                            evst_reg   <= hdr_status;
                            open_reg   <= (hdr_status == ST_APPLIED);
                            if (hdr_status == ST_APPLIED)
                            begin
                                seq_reg <= last_reg;
                            end
                        end
                        MODE_EVENT_LEVEL:
                        begin
                            status_reg <= (evst_reg != ST_APPLIED) ? evst_reg : ST_STALE;
                        end
                        default:
                        begin
                            status_reg <= ST_APPLIED;
                        end
                    endcase
                end
                CMD_SEARCH_INIT:
                begin
                    i_reg      <= '0;
                    hit_reg    <= 1'b0;
                    status_reg <= ST_APPLIED;
                end
                CMD_NEXT_I:    i_reg <= i_reg + CNT_W'(1);
                CMD_LATCH_HIT: hit_reg <= (rd_price == price_reg);
                CMD_OVERFLOW:  status_reg <= ST_OVERFLOW;
                CMD_ER_INIT:   j_reg <= i_reg[IDX_W-1:0];
                CMD_WRITE_UP:  j_reg <= j_reg + IDX_W'(1);
                CMD_WRITE_DOWN: j_reg <= j_reg - IDX_W'(1);
                CMD_ER_END:
                begin
                    if (side_reg)
                    begin
                        ask_cnt_reg <= n - CNT_W'(1);
                    end
                    else
                    begin
                        bid_cnt_reg <= n - CNT_W'(1);
                    end
                end
                CMD_IN_INIT:
                begin
                    j_reg      <= n_full ? IDX_W'(BOOK_DEPTH - 1) : n[IDX_W-1:0];
                    status_reg <= n_full ? ST_OVERFLOW : ST_APPLIED;
                end
                CMD_IN_END:
                begin
                    if (!n_full)
                    begin
                        if (side_reg)
                        begin
                            ask_cnt_reg <= n + CNT_W'(1);
                        end
                        else
                        begin
                            bid_cnt_reg <= n + CNT_W'(1);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== rtl/order_book_level_updater.sv =====
// Order book level updater: keeps sorted bid and ask price-level tables.
// Input channel s_t*: one beat per item (snapshot start, snapshot level,
// event header or event level), accepted when s_tvalid and s_tready are high.
// Output channel m_t*: exactly one beat per input item, carrying status,
// best bid and ask, applied sequence and total level count.
// One item is handled at a time. For a snapshot start, a header or a skipped
// level, the controller goes from dispatch straight to emit, and m_tvalid is
// registered from the emit step. A level update scans its side's table
// through the single memory read port, a read and a compare state per level
// passed, then moves the entries behind the change by one place, a read and a
// write state per entry; when the price is found and only its quantity
// changes, that entry is rewritten in place and no entry moves.
// Reset empties both tables, clears the sequence and closes any event;
// table memory is not cleared since entries beyond the level count are
// never read.
// A result beat is held in an output register; the next item is taken while
// it waits, and the block stops before emitting the following beat until
// the receiver takes it.
module order_book_level_updater
    import oblu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // mode, side, price, quantity, first_id, last_id
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // status, best_bid_valid, best_bid_price, best_bid_size, best_ask_valid,
    // best_ask_price, best_ask_size, applied_sequence, level_count
    output logic [OUT_W-1:0] m_tdata
);

    cmd_t       cmd;
    dp_status_t stat;

    oblu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .stat     (stat),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    oblu_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (s_tdata),
        .out_ready (m_tready),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

endmodule

// ===== rtl/oblu_checker.sv =====
`include "order_book_level_updater_assert.svh"

module oblu_checker
    import oblu_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    `OBLU_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `OBLU_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `OBLU_ASSERT_NOW(a_count_range, clk, rst_n, m_tvalid, m_tdata[329:320] <= 10'd512)
    `OBLU_ASSERT_NOW(a_empty_bid, clk, rst_n, m_tvalid && !m_tdata[2], m_tdata[128:3] == '0)

endmodule

bind order_book_level_updater oblu_checker u_oblu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/sv/tb_order_book_level_updater.sv =====
module tb_order_book_level_updater;
    import oblu_pkg::*;

    typedef struct packed {
        logic [63:0] last_id;
        logic [63:0] first_id;
        logic [62:0] quantity;
        logic [62:0] price;
        logic        side;
        logic [1:0]  mode;
    } book_item_t;

    typedef struct packed {
        logic [9:0]  level_count;
        logic [63:0] applied_sequence;
        logic [62:0] best_ask_size;
        logic [62:0] best_ask_price;
        logic        best_ask_valid;
        logic [62:0] best_bid_size;
        logic [62:0] best_bid_price;
        logic        best_bid_valid;
        logic [1:0]  status;
    } top_of_book_t;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;

    logic [62:0]  level_px [2][$];
    logic [62:0]  level_qty[2][$];
    logic [63:0]  book_seq;
    logic         book_event_open;
    logic [1:0]   book_event_status;
    top_of_book_t pending_tops[$];
    top_of_book_t got_top;
    top_of_book_t want_top;
    int           items_sent;
    int           results_seen;
    int           overflow_seen;
    int           errors;
    int           hold_cycles;
    bit           tx_idle_on;
    bit           rx_idle_on;

    order_book_level_updater dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [1:0] book_set(int s, logic [62:0] p, logic [62:0] q);
        int n;
        int i;
        n = level_px[s].size();
        i = 0;
        while (i < n && (s == 1 ? level_px[s][i] < p : level_px[s][i] > p))
            i++;
        if (i < n && level_px[s][i] == p)
        begin
            level_qty[s][i] = q;
            return ST_APPLIED;
        end
        if (n == BOOK_DEPTH)
        begin
            if (i >= n)
                return ST_OVERFLOW;
            level_px[s].insert(i, p);
            level_qty[s].insert(i, q);
            void'(level_px[s].pop_back());
            void'(level_qty[s].pop_back());
            return ST_OVERFLOW;
        end
        level_px[s].insert(i, p);
        level_qty[s].insert(i, q);
        return ST_APPLIED;
    endfunction

    function automatic void book_erase(int s, logic [62:0] p);
        int i;
        for (i = 0; i < level_px[s].size(); i++)
        begin
            if (level_px[s][i] == p)
            begin
                level_px[s].delete(i);
                level_qty[s].delete(i);
                return;
            end
        end
    endfunction

    function automatic top_of_book_t book_apply(book_item_t it);
        top_of_book_t r;
        logic [1:0]   st;
        st = ST_APPLIED;
        case (it.mode)
            MODE_SNAP_START:
            begin
                level_px[0].delete();
                level_qty[0].delete();
                level_px[1].delete();
                level_qty[1].delete();
                book_seq = it.last_id;
                book_event_open = 1'b0;
                book_event_status = ST_APPLIED;
            end
            MODE_SNAP_LEVEL:
            begin
                if (it.quantity != 0)
                    st = book_set(it.side, it.price, it.quantity);
            end
            MODE_EVENT_HDR:
            begin
                if (it.last_id < book_seq)
                begin
                    st = ST_STALE;
                    book_event_open = 1'b0;
                end
                else if (book_seq != '1 && it.first_id > book_seq + 64'd1)
                begin
                    st = ST_GAP;
                    book_event_open = 1'b0;
                end
                else
                begin
                    book_seq = it.last_id;
                    book_event_open = 1'b1;
                end
                book_event_status = st;
            end
            default:
            begin
                if (book_event_open)
                begin
                    if (it.quantity == 0)
                        book_erase(it.side, it.price);
                    else
                        st = book_set(it.side, it.price, it.quantity);
                end
                else
                    st = (book_event_status != ST_APPLIED) ? book_event_status : ST_STALE;
            end
        endcase
        r = '0;
        r.status = st;
        if (level_px[0].size() != 0)
        begin
            r.best_bid_valid = 1'b1;
            r.best_bid_price = level_px[0][0];
            r.best_bid_size  = level_qty[0][0];
        end
        if (level_px[1].size() != 0)
        begin
            r.best_ask_valid = 1'b1;
            r.best_ask_price = level_px[1][0];
            r.best_ask_size  = level_qty[1][0];
        end
        r.applied_sequence = book_seq;
        r.level_count = 10'((level_px[0].size() + level_px[1].size()) & 32'h3FF);
        return r;
    endfunction

    task automatic send_item(book_item_t it);
        while (tx_idle_on && $urandom_range(99) < 18)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - $bits(book_item_t)){1'b0}}, it};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_tops.push_back(book_apply(it));
        items_sent++;
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_tops.size() != 0)
            @(posedge clk);
    endtask

    function automatic book_item_t make_item(logic [1:0] m, logic s, logic [62:0] p,
                                             logic [62:0] q, logic [63:0] f,
                                             logic [63:0] l);
        book_item_t it;
        it.mode = m;
        it.side = s;
        it.price = p;
        it.quantity = q;
        it.first_id = f;
        it.last_id = l;
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch on %s: got %h, expected %h", field, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_top = m_tdata[$bits(top_of_book_t)-1:0];
            results_seen++;
            if (pending_tops.size() == 0)
                report_mismatch("unexpected beat", 64'(got_top.status), 64'd0);
            else
            begin
                want_top = pending_tops.pop_front();
                if (want_top.status == ST_OVERFLOW)
                    overflow_seen++;
                if (got_top.status !== want_top.status)
                    report_mismatch("status", 64'(got_top.status), 64'(want_top.status));
                if (got_top.best_bid_valid !== want_top.best_bid_valid)
                    report_mismatch("best_bid_valid", 64'(got_top.best_bid_valid),
                                    64'(want_top.best_bid_valid));
                if (got_top.best_bid_price !== want_top.best_bid_price)
                    report_mismatch("best_bid_price", 64'(got_top.best_bid_price),
                                    64'(want_top.best_bid_price));
                if (got_top.best_bid_size !== want_top.best_bid_size)
                    report_mismatch("best_bid_size", 64'(got_top.best_bid_size),
                                    64'(want_top.best_bid_size));
                if (got_top.best_ask_valid !== want_top.best_ask_valid)
                    report_mismatch("best_ask_valid", 64'(got_top.best_ask_valid),
                                    64'(want_top.best_ask_valid));
                if (got_top.best_ask_price !== want_top.best_ask_price)
                    report_mismatch("best_ask_price", 64'(got_top.best_ask_price),
                                    64'(want_top.best_ask_price));
                if (got_top.best_ask_size !== want_top.best_ask_size)
                    report_mismatch("best_ask_size", 64'(got_top.best_ask_size),
                                    64'(want_top.best_ask_size));
                if (got_top.applied_sequence !== want_top.applied_sequence)
                    report_mismatch("applied_sequence", got_top.applied_sequence,
                                    want_top.applied_sequence);
                if (got_top.level_count !== want_top.level_count)
                    report_mismatch("level_count", 64'(got_top.level_count),
                                    64'(want_top.level_count));
            end
        end
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= !(rx_idle_on && $urandom_range(99) < 18);
    end

    task automatic test_directed();
        localparam logic [62:0] PMAX = '1;
        localparam logic [63:0] IDMAX = '1;
        send_item(make_item(MODE_EVENT_LEVEL, 1'b0, 63'd5, 63'd5, 64'd0, 64'd0));
        send_item(make_item(MODE_SNAP_START, 1'b0, '0, '0, 64'd0, 64'd100));
        send_item(make_item(MODE_SNAP_LEVEL, 1'b0, PMAX, PMAX, 64'd0, 64'd0));
        send_item(make_item(MODE_SNAP_LEVEL, 1'b0, 63'd1000, 63'd7, 64'd0, 64'd0));
        send_item(make_item(MODE_SNAP_LEVEL, 1'b1, 63'd0, 63'd1, 64'd0, 64'd0));
        send_item(make_item(MODE_SNAP_LEVEL, 1'b1, 63'd2000, 63'd3, 64'd0, 64'd0));
        send_item(make_item(MODE_SNAP_LEVEL, 1'b1, 63'd50, 63'd0, 64'd0, 64'd0));
        send_item(make_item(MODE_EVENT_HDR, 1'b0, '0, '0, 64'd1, 64'd5));
        send_item(make_item(MODE_EVENT_LEVEL, 1'b0, 63'd1000, 63'd0, 64'd0, 64'd0));
        send_item(make_item(MODE_EVENT_HDR, 1'b0, '0, '0, 64'd200, 64'd210));
        send_item(make_item(MODE_EVENT_LEVEL, 1'b1, 63'd0, 63'd9, 64'd0, 64'd0));
        send_item(make_item(MODE_EVENT_HDR, 1'b0, '0, '0, 64'd101, 64'd110));
        send_item(make_item(MODE_EVENT_LEVEL, 1'b0, PMAX, 63'd0, 64'd0, 64'd0));
        send_item(make_item(MODE_EVENT_LEVEL, 1'b0, 63'd77, 63'd0, 64'd0, 64'd0));
        send_item(make_item(MODE_EVENT_LEVEL, 1'b1, 63'd0, PMAX, 64'd0, 64'd0));
        send_item(make_item(MODE_EVENT_LEVEL, 1'b1, 63'd10, 63'd4, 64'd0, 64'd0));
        send_item(make_item(MODE_EVENT_HDR, 1'b0, '0, '0, 64'd111, 64'd111));
        send_item(make_item(MODE_EVENT_LEVEL, 1'b1, 63'd0, 63'd0, 64'd0, 64'd0));
        send_item(make_item(MODE_SNAP_START, 1'b1, PMAX, PMAX, IDMAX, IDMAX));
        send_item(make_item(MODE_EVENT_HDR, 1'b0, '0, '0, IDMAX, IDMAX));
        send_item(make_item(MODE_EVENT_LEVEL, 1'b0, 63'd3, 63'd3, 64'd0, 64'd0));
        send_item(make_item(MODE_EVENT_HDR, 1'b1, PMAX, PMAX, 64'd0, 64'd0));
        send_item(make_item(MODE_EVENT_LEVEL, 1'b0, 63'd4, 63'd4, 64'd0, 64'd0));
        wait_drain();
    endtask

    task automatic test_overflow();
        int k;
        send_item(make_item(MODE_SNAP_START, 1'b0, '0, '0, 64'd0, 64'd1));
        hold_cycles <= 400;
        for (k = 0; k < BOOK_DEPTH; k++)
            send_item(make_item(MODE_SNAP_LEVEL, 1'b0, 63'(1000 + k), 63'(k + 1),
                                64'd0, 64'd0));
        send_item(make_item(MODE_SNAP_LEVEL, 1'b0, 63'd10, 63'd5, 64'd0, 64'd0));
        send_item(make_item(MODE_SNAP_LEVEL, 1'b0, 63'd5000, 63'd6, 64'd0, 64'd0));
        send_item(make_item(MODE_SNAP_LEVEL, 1'b0, 63'd1100, 63'd8, 64'd0, 64'd0));
        send_item(make_item(MODE_SNAP_LEVEL, 1'b1, 63'd900, 63'd2, 64'd0, 64'd0));
        send_item(make_item(MODE_EVENT_HDR, 1'b0, '0, '0, 64'd2, 64'd3));
        send_item(make_item(MODE_EVENT_LEVEL, 1'b0, 63'd5000, 63'd0, 64'd0, 64'd0));
        send_item(make_item(MODE_EVENT_LEVEL, 1'b0, 63'd7000, 63'd1, 64'd0, 64'd0));
        wait_drain();
    endtask

    task automatic test_random(int target);
        logic [62:0] base;
        logic [63:0] f;
        int          k;
        int          n;
        while (items_sent < target)
        begin
            tx_idle_on = (items_sent % 300) > 120;
            rx_idle_on = tx_idle_on;
            if ($urandom_range(4) == 0)
            begin
                send_item(make_item(2'($urandom), 1'($urandom), 63'(rand64()),
                                    ($urandom_range(3) == 0) ? '0 : 63'(rand64()),
                                    rand64(), rand64()));
                continue;
            end
            base = 63'(rand64());
            f = ($urandom_range(3) == 0) ? 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(3)
                                         : rand64();
            send_item(make_item(MODE_SNAP_START, 1'b0, '0, '0, 64'd0, f));
            n = $urandom_range(6);
            for (k = 0; k < n; k++)
                send_item(make_item(MODE_SNAP_LEVEL, 1'($urandom),
                                    base + $urandom_range(23), 63'(rand64()),
                                    64'd0, 64'd0));
            n = $urandom_range(20, 4);
            for (k = 0; k < n; k++)
            begin
                if ($urandom_range(3) == 0)
                begin
                    if ($urandom_range(5) == 0)
                        f = book_seq + 64'd2 + $urandom_range(5);
                    else
                        f = book_seq + 64'd1 - $urandom_range(3);
                    send_item(make_item(MODE_EVENT_HDR, 1'b0, '0, '0, f,
                                        f + $urandom_range(4)));
                end
                else
                    send_item(make_item(MODE_EVENT_LEVEL, 1'($urandom),
                                        base + $urandom_range(23),
                                        ($urandom_range(3) == 0) ? '0
                                        : (($urandom_range(1) == 0) ? 63'(rand64())
                                                                     : 63'($urandom_range(99))),
                                        64'd0, 64'd0));
            end
        end
        wait_drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        book_seq = '0;
        book_event_open = 1'b0;
        book_event_status = ST_APPLIED;
        items_sent = 0;
        results_seen = 0;
        overflow_seen = 0;
        errors = 0;
        hold_cycles = 0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_overflow();
        test_random(750);
        repeat (20) @(posedge clk);
        $display("Covered %0d items and %0d result beats, %0d of them overflows,",
                 items_sent, results_seen, overflow_seen);
        $display("with a full bid table, stale and gap headers and back-pressure.");
        if (errors == 0 && pending_tops.size() == 0)
            $display("tb_order_book_level_updater: PASS");
        else
            $display("tb_order_book_level_updater: FAIL");
        $finish;
    end

    initial
    begin
        #100000000;
        $display("tb_order_book_level_updater: FAIL");
        $finish;
    end

endmodule
